// ===== rtl/tmd_pkg.sv =====
`default_nettype none

package tmd_pkg;

   // sample and result width, unsigned Q12.4
   localparam int unsigned SampleW = 16;

   // default number of samples per block
   localparam int unsigned BlockLenDefault = 5;

   // running minimum start value
   localparam logic [SampleW-1:0] MinStart = {SampleW{1'b1}};

   // running maximum start value
   localparam logic [SampleW-1:0] MaxStart = '0;

endpackage

`default_nettype wire

// ===== rtl/tmd_accum.sv =====
`default_nettype none

module tmd_accum
   import tmd_pkg::*;
#(
   parameter int unsigned BLOCK_LEN = BlockLenDefault,
   localparam int unsigned CntW = $clog2(BLOCK_LEN),
   localparam int unsigned SumW = SampleW + $clog2(BLOCK_LEN)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // sample transfer
   input  wire logic               smp_valid,
   output logic                    smp_ready,
   input  wire logic [SampleW-1:0] smp_data,
   // finished block toward the divide stage
   output logic                    blk_valid,
   input  wire logic               blk_ready,
   output logic [SumW-1:0]         blk_sum,
   output logic [SampleW-1:0]      blk_max,
   output logic [SampleW-1:0]      blk_min
);

   logic [SumW-1:0]    sum_ff, sum_in;
   logic [SampleW-1:0] max_ff, max_in;
   logic [SampleW-1:0] min_ff, min_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               blk_valid_ff, blk_valid_in;
   logic [SumW-1:0]    blk_sum_ff, blk_sum_in;
   logic [SampleW-1:0] blk_max_ff, blk_max_in;
   logic [SampleW-1:0] blk_min_ff, blk_min_in;

   logic               take;
   logic               last;
   logic [SumW-1:0]    sum_upd;
   logic [SampleW-1:0] max_upd;
   logic [SampleW-1:0] min_upd;

   // a sample may enter when the block slot is free or drains this cycle
   assign smp_ready = !blk_valid_ff || blk_ready;
   assign take      = smp_valid && smp_ready;
   assign last      = (cnt_ff == CntW'(BLOCK_LEN - 1));

   // running statistics including the new sample
   assign sum_upd = sum_ff + SumW'(smp_data);
   assign max_upd = (smp_data > max_ff) ? smp_data : max_ff;
   assign min_upd = (smp_data < min_ff) ? smp_data : min_ff;

   // next state of the running block and the hand-off slot
   always_comb begin
      sum_in       = sum_ff;
      max_in       = max_ff;
      min_in       = min_ff;
      cnt_in       = cnt_ff;
      blk_valid_in = blk_valid_ff && !blk_ready;
      blk_sum_in   = blk_sum_ff;
      blk_max_in   = blk_max_ff;
      blk_min_in   = blk_min_ff;
      if (take) begin
         if (last) begin
            sum_in       = '0;
            max_in       = MaxStart;
            min_in       = MinStart;
            cnt_in       = '0;
            blk_valid_in = 1'b1;
            blk_sum_in   = sum_upd;
            blk_max_in   = max_upd;
            blk_min_in   = min_upd;
         end else begin
            sum_in = sum_upd;
            max_in = max_upd;
            min_in = min_upd;
            cnt_in = cnt_ff + CntW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         max_ff       <= MaxStart;
         min_ff       <= MinStart;
         cnt_ff       <= '0;
         blk_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         cnt_ff       <= cnt_in;
         blk_valid_ff <= blk_valid_in;
      end
      blk_sum_ff <= blk_sum_in;
      blk_max_ff <= blk_max_in;
      blk_min_ff <= blk_min_in;
   end

   assign blk_valid = blk_valid_ff;
   assign blk_sum   = blk_sum_ff;
   assign blk_max   = blk_max_ff;
   assign blk_min   = blk_min_ff;

endmodule

`default_nettype wire

// ===== rtl/tmd_div.sv =====
`default_nettype none

module tmd_div
   import tmd_pkg::*;
#(
   parameter int unsigned BLOCK_LEN = BlockLenDefault,
   localparam int unsigned SumW = SampleW + $clog2(BLOCK_LEN)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // finished block from the accumulator
   input  wire logic               blk_valid,
   output logic                    blk_ready,
   input  wire logic [SumW-1:0]    blk_sum,
   input  wire logic [SampleW-1:0] blk_max,
   input  wire logic [SampleW-1:0] blk_min,
   // result transfer
   output logic                    res_valid,
   input  wire logic               res_ready,
   output logic [SampleW-1:0]      res_data
);

   // divisor is the count of kept samples, at least one
   localparam int unsigned Div   = (BLOCK_LEN > 3) ? (BLOCK_LEN - 2) : 1;
   localparam int unsigned ShW   = $clog2(Div);
   localparam int unsigned Shift = SumW + ShW;
   localparam int unsigned MultW = SumW + 2;
   localparam int unsigned ProdW = SumW + MultW;
   // rounded-up reciprocal, exact floor for every operand below 2**SumW
   localparam logic [MultW-1:0] Mult = MultW'(((64'd1 << Shift) + Div - 1) / Div);

   logic               res_valid_ff, res_valid_in;
   logic [SampleW-1:0] res_data_ff, res_data_in;

   logic [SumW-1:0]    trimmed;
   logic [ProdW-1:0]   product;

   // drop one largest and one smallest sample
   assign trimmed = blk_sum - SumW'(blk_max) - SumW'(blk_min);

   // divide by the constant through the reciprocal
   assign product = ProdW'(trimmed) * ProdW'(Mult);

   assign blk_ready = !res_valid_ff || res_ready;

   // result register update
   always_comb begin
      res_valid_in = res_valid_ff && !res_ready;
      res_data_in  = res_data_ff;
      if (blk_valid && blk_ready) begin
         res_valid_in = 1'b1;
         res_data_in  = product[Shift +: SampleW];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else begin
         res_valid_ff <= res_valid_in;
      end
      res_data_ff <= res_data_in;
   end

   assign res_valid = res_valid_ff;
   assign res_data  = res_data_ff;

endmodule

`default_nettype wire

// ===== rtl/trimmed_mean_decimator_unit.sv =====
`default_nettype none

// Trimmed-mean decimator: takes one unsigned Q12.4 distance sample per
// transfer and groups the samples into blocks of BLOCK_LEN (3 to 16, default
// 5). On the last sample of each block it returns one result: the block sum
// minus one largest and one smallest sample, divided by BLOCK_LEN - 2 (by one
// when BLOCK_LEN is 3) and truncated. Zero samples count as ordinary samples.
// A sample is taken every cycle unless a finished block waits on a stalled
// result channel. The result of a block passes from the hand-off register
// after the accumulator to the result register after the reciprocal
// multiplier. There is no configuration.
module trimmed_mean_decimator_unit
   import tmd_pkg::*;
#(
   parameter int unsigned BLOCK_LEN = BlockLenDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // sample channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] sample
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [15:0] filtered
);

   localparam int unsigned SumW = SampleW + $clog2(BLOCK_LEN);

   logic               blk_valid;
   logic               blk_ready;
   logic [SumW-1:0]    blk_sum;
   logic [SampleW-1:0] blk_max;
   logic [SampleW-1:0] blk_min;

   // running sum and extremes of the block being filled
   tmd_accum #(
      .BLOCK_LEN(BLOCK_LEN)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .smp_valid (req_tvalid),
      .smp_ready (req_tready),
      .smp_data  (req_tdata),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_sum   (blk_sum),
      .blk_max   (blk_max),
      .blk_min   (blk_min)
   );

   // trim, divide and hold the result
   tmd_div #(
      .BLOCK_LEN(BLOCK_LEN)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .blk_valid (blk_valid),
      .blk_ready (blk_ready),
      .blk_sum   (blk_sum),
      .blk_max   (blk_max),
      .blk_min   (blk_min),
      .res_valid (rsp_tvalid),
      .res_ready (rsp_tready),
      .res_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmd_pkg::*;

   localparam int unsigned BlockLen    = BlockLenDefault;
   localparam int unsigned RandomItems = 1150;
   localparam int unsigned CycleLimit  = 200000;
   localparam int unsigned ReportMax   = 10;
   localparam int unsigned DrainCycles = 8;

   // predicts the trimmed mean of each block and holds it until the result transfer
   class trimmed_mean_scoreboard;
      int unsigned              block_len;
      logic [23:0]              block_sum;
      logic [SampleW-1:0]       block_max;
      logic [SampleW-1:0]       block_min;
      int unsigned              block_fill;
      logic [SampleW-1:0]       filtered_due[$];
      int unsigned              fault_count;

      function new(int unsigned len);
         block_len   = len;
         fault_count = 0;
         clear_block();
      endfunction

      function void clear_block();
         block_sum  = '0;
         block_max  = MaxStart;
         block_min  = MinStart;
         block_fill = 0;
      endfunction

      // accepted sample: update the running block and queue a mean on the last one
      function void take_sample(logic [SampleW-1:0] sample);
         logic [23:0] trimmed;
         int unsigned divisor;
         block_sum = block_sum + 24'(sample);
         if (sample > block_max) block_max = sample;
         if (sample < block_min) block_min = sample;
         block_fill++;
         if (block_fill >= block_len) begin
            divisor = (block_len > 3) ? block_len - 2 : 1;
            trimmed = block_sum - 24'(block_max) - 24'(block_min);
            filtered_due.push_back(SampleW'(trimmed / 24'(divisor)));
            clear_block();
         end
      endfunction

      // result transfer: compare with the oldest predicted mean
      function void check_filtered(logic [SampleW-1:0] actual);
         logic [SampleW-1:0] expected;
         if (filtered_due.size() == 0) begin
            fault_count++;
            if (fault_count <= ReportMax)
               $display("unexpected result: filtered %h", actual);
         end else begin
            expected = filtered_due.pop_front();
            if (actual !== expected) begin
               fault_count++;
               if (fault_count <= ReportMax)
                  $display("filtered mismatch: expected %h, actual %h", expected, actual);
            end
         end
      endfunction

      function int unsigned pending();
         return filtered_due.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;    // [15:0] sample
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [15:0] filtered

   trimmed_mean_scoreboard sb = new(BlockLen);

   int unsigned  cycle_count = 0;
   int unsigned  ready_mode  = 0;
   int unsigned  ready_left  = 0;
   int unsigned  ready_phase = 0;
   logic [15:0]  last_sample = '0;

   trimmed_mean_decimator_unit #(.BLOCK_LEN(BlockLen)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // clock
   initial begin
      forever #10 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: check each transfer, stall on a pattern that changes now and then
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_filtered(rsp_tdata);
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(20, 120);
      end else begin
         ready_left--;
      end
      ready_phase++;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (ready_phase % 4 == 0);
         default: rsp_tready <= (ready_phase % 16 >= 11);
      endcase
   end

   // one sample transfer; valid stays high for a following item
   task automatic send_sample(input logic [15:0] value);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      sb.take_sample(value);
      last_sample = value;
   endtask

   task automatic hold_off(input int unsigned cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop sending until every predicted mean has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // sample mix: full range, small values, extremes, repeats and clusters
   function automatic logic [15:0] pick_sample();
      int unsigned kind;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2, 3: return 16'($urandom);
         4: return 16'($urandom_range(0, 255));
         5: return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
         6: return 16'($urandom_range(16'hFF00, 16'hFFFF));
         7: return last_sample;
         8: return 16'h1 << $urandom_range(0, 15);
         default: return last_sample ^ 16'($urandom_range(0, 3));
      endcase
   endfunction

   // stimulus
   initial begin
      logic [15:0] directed[$];
      int unsigned sent;
      int unsigned burst;
      int unsigned gap;
      bit          paused;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero block, full-scale block, all equal, shared extremes with zeros, ascending
      directed = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                   16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   16'h1234, 16'h1234, 16'h1234, 16'h1234, 16'h1234,
                   16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0064,
                   16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005};
      foreach (directed[i]) begin
         send_sample(directed[i]);
         if (i % 7 == 3) hold_off(2);
      end
      wait_drained();

      // random bursts with random gaps
      sent   = 0;
      paused = 0;
      while (sent < RandomItems) begin
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
         for (int unsigned i = 0; i < burst && sent < RandomItems; i++) begin
            send_sample(pick_sample());
            sent++;
         end
         if (!paused && sent >= RandomItems / 2) begin
            paused = 1;
            wait_drained();
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) hold_off(gap);
      end

      // drain and settle
      wait_drained();
      repeat (DrainCycles) @(posedge clock);
      if (sb.fault_count == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/tmd_pkg.sv
rtl/tmd_accum.sv
rtl/tmd_div.sv
rtl/trimmed_mean_decimator_unit.sv
verif/tb.sv
